@@ sv/vbb_pkg.sv @@
package vbb_pkg;

  localparam int ACTION_W  = 2;
  localparam int COORD_W   = 6;
  localparam int DIM_W     = 7;
  localparam int CFG_IDX_W = 2;

  // Total number of coordinate values that a 6-bit coordinate can take.
  localparam int COORD_COUNT = 2 ** COORD_W;

  typedef enum logic [ACTION_W-1:0] {
    ACT_SET   = 2'd0,
    ACT_GET   = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_BOX   = 2'd3
  } act_t;

  localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVELS = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MODIFY,
    ST_FETCH,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_EMIT
  } state_t;

endpackage

@@ sv/vbb_if.sv @@
interface vbb_in_if import vbb_pkg::*;;
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [COORD_W-1:0]  col;
  logic [COORD_W-1:0]  row;
  logic [COORD_W-1:0]  level;

  modport source (output valid, action, col, row, level, input ready);
  modport sink   (input valid, action, col, row, level, output ready);
endinterface

interface vbb_out_if import vbb_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic                    bit_value;
  logic                    area_found;
  logic        [DIM_W-1:0] x_start;
  logic signed [DIM_W-1:0] x_end;
  logic        [DIM_W-1:0] y_start;
  logic signed [DIM_W-1:0] y_end;
  logic        [DIM_W-1:0] z_start;
  logic signed [DIM_W-1:0] z_end;

  modport source (output valid, bit_value, area_found, x_start, x_end, y_start, y_end,
                  z_start, z_end, input ready);
  modport sink   (input valid, bit_value, area_found, x_start, x_end, y_start, y_end,
                  z_start, z_end, output ready);
endinterface

@@ sv/vbb_ram.sv @@
module vbb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/voxel_bitmap_bounding_box_top.sv @@
// Blocked 3D occupancy bitmap kept in one single-port-read, single-port-write RAM of
// CUBE_EDGE^3-bit words, one word per cube of voxels. One item is handled at a time.
// Set and get pass through accept, RAM read, then write-back or result, or go from accept
// straight to the result when the coordinate lies outside the active volume and the RAM is
// left alone; clear is a sweep that zeroes one word a cycle, 4096 words by default, and
// bounding box reads every cube, partial edge cubes included, that the active volume
// spans: the RAM read port delivers one word per cycle and each word is folded into the
// running extent as it arrives. After reset the same zeroing sweep runs with in_bus.ready
// low; configuration writes are taken at any time. A finished result sits in an output
// register, so the next item is accepted while the previous result waits to be taken;
// the last cycle of an item repeats for as long as that register still holds an earlier
// result that has not been taken.
module voxel_bitmap_bounding_box_top import vbb_pkg::*; #(
  parameter int CUBE_EDGE  = 4,
  parameter int MAX_COLS   = 64,
  parameter int MAX_ROWS   = 64,
  parameter int MAX_LEVELS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_wdata,
  vbb_in_if.sink               in_bus,
  vbb_out_if.source            out_bus
);

  localparam int CUBES_X = (MAX_COLS + CUBE_EDGE - 1) / CUBE_EDGE;
  localparam int CUBES_Y = (MAX_ROWS + CUBE_EDGE - 1) / CUBE_EDGE;
  localparam int CUBES_Z = (MAX_LEVELS + CUBE_EDGE - 1) / CUBE_EDGE;
  localparam int DEPTH   = CUBES_X * CUBES_Y * CUBES_Z;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WORD_W  = CUBE_EDGE * CUBE_EDGE * CUBE_EDGE;
  localparam int BP_W    = $clog2(WORD_W);
  localparam int RW      = $clog2(CUBE_EDGE);
  localparam int XW      = (CUBES_X > 1) ? $clog2(CUBES_X) : 1;
  localparam int YW      = (CUBES_Y > 1) ? $clog2(CUBES_Y) : 1;
  localparam int ZW      = (CUBES_Z > 1) ? $clog2(CUBES_Z) : 1;
  // Cube base coordinates stay below 127, plus one cube edge of headroom.
  localparam int BASE_W  = DIM_W + 1;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v, input int maxv);
    logic [DIM_W-1:0] d;
    d = v;
    if (v == '0) begin
      d = DIM_W'(1);
    end else if (int'(v) > maxv) begin
      d = DIM_W'(maxv);
    end
    return d;
  endfunction

  function automatic logic [AW-1:0] word_addr(input logic [AW-1:0] qx, input logic [AW-1:0] qy,
                                              input logic [AW-1:0] qz);
    return AW'((qx * AW'(CUBES_Y) + qy) * AW'(CUBES_Z) + qz);
  endfunction

  // Configuration registers.
  logic [DIM_W-1:0] cols_r, rows_r, levels_r;
  logic [DIM_W-1:0] dx, dy, dz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r   <= DIM_RESET;
      rows_r   <= DIM_RESET;
      levels_r <= DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COLS:   cols_r   <= cfg_wdata;
        CFG_ROWS:   rows_r   <= cfg_wdata;
        CFG_LEVELS: levels_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign dx = eff_dim(cols_r, MAX_COLS);
  assign dy = eff_dim(rows_r, MAX_ROWS);
  assign dz = eff_dim(levels_r, MAX_LEVELS);

  // Coordinate to cube index and offset inside the cube.
  logic [COORD_W-1:0] quot_lut [COORD_COUNT];
  logic [RW-1:0]      rem_lut  [COORD_COUNT];

  for (genvar gi = 0; gi < COORD_COUNT; gi++) begin : g_lut
    assign quot_lut[gi] = COORD_W'(gi / CUBE_EDGE);
    assign rem_lut[gi]  = RW'(gi % CUBE_EDGE);
  end

  act_t            in_act;
  logic            in_accept;
  logic            in_inside;
  logic [AW-1:0]   in_addr;
  logic [BP_W-1:0] in_bitpos;

  assign in_act    = act_t'(in_bus.action);
  assign in_accept = in_bus.valid && in_bus.ready;
  assign in_inside = ({1'b0, in_bus.col} < dx) && ({1'b0, in_bus.row} < dy) &&
                     ({1'b0, in_bus.level} < dz);
  assign in_addr   = word_addr(AW'(quot_lut[in_bus.col]), AW'(quot_lut[in_bus.row]),
                               AW'(quot_lut[in_bus.level]));
  assign in_bitpos = BP_W'(BP_W'(rem_lut[in_bus.col]) * BP_W'(CUBE_EDGE * CUBE_EDGE) +
                           BP_W'(rem_lut[in_bus.row]) * BP_W'(CUBE_EDGE) +
                           BP_W'(rem_lut[in_bus.level]));

  // Control state.
  state_t          state_r, state_nxt;
  act_t            act_r;
  logic [AW-1:0]   addr_r;
  logic [BP_W-1:0] bitpos_r;
  logic [AW-1:0]   clr_addr_r;
  logic            clr_emit_r;
  logic            bit_r;
  logic [XW-1:0]   cx_r;
  logic [YW-1:0]   cy_r;
  logic [ZW-1:0]   cz_r;
  logic            pend_r, pend_nxt;
  logic [BASE_W-1:0] pbx_r, pby_r, pbz_r;

  // RAM.
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  vbb_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Scan position.
  logic [BASE_W-1:0] bx, by, bz;
  logic              x_last, y_last, z_last, clr_last;
  logic [AW-1:0]     scan_addr;
  logic              out_load;
  logic              out_valid_r;

  assign bx        = BASE_W'(cx_r) * BASE_W'(CUBE_EDGE);
  assign by        = BASE_W'(cy_r) * BASE_W'(CUBE_EDGE);
  assign bz        = BASE_W'(cz_r) * BASE_W'(CUBE_EDGE);
  assign x_last    = (bx + BASE_W'(CUBE_EDGE)) >= BASE_W'(dx);
  assign y_last    = (by + BASE_W'(CUBE_EDGE)) >= BASE_W'(dy);
  assign z_last    = (bz + BASE_W'(CUBE_EDGE)) >= BASE_W'(dz);
  assign scan_addr = word_addr(AW'(cx_r), AW'(cy_r), AW'(cz_r));
  assign clr_last  = clr_addr_r == AW'(DEPTH - 1);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_last) begin
          state_nxt = clr_emit_r ? ST_EMIT : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          case (in_act)
            ACT_SET:   state_nxt = in_inside ? ST_MODIFY : ST_EMIT;
            ACT_GET:   state_nxt = in_inside ? ST_FETCH : ST_EMIT;
            ACT_CLEAR: state_nxt = ST_CLEAR;
            ACT_BOX:   state_nxt = ST_SCAN;
            default:   state_nxt = ST_EMIT;
          endcase
        end
      end
      ST_MODIFY, ST_FETCH: state_nxt = ST_EMIT;
      ST_SCAN: begin
        if (x_last && y_last && z_last) begin
          state_nxt = ST_SCAN_LAST;
        end
      end
      ST_SCAN_LAST: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // FSM outputs.
  always_comb begin
    ram_we       = 1'b0;
    ram_waddr    = addr_r;
    ram_wdata    = ram_rdata | (WORD_W'(1) << bitpos_r);
    ram_raddr    = scan_addr;
    in_bus.ready = 1'b0;
    out_load     = 1'b0;
    pend_nxt     = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        in_bus.ready = 1'b1;
        ram_raddr    = in_addr;
      end
      ST_MODIFY: ram_we   = 1'b1;
      ST_SCAN:   pend_nxt = 1'b1;
      ST_EMIT:   out_load = !out_valid_r || out_bus.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      clr_emit_r <= 1'b0;
      pend_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end else begin
        clr_addr_r <= '0;
      end
      if (in_accept) begin
        clr_emit_r <= 1'b1;
      end
    end
  end

  // Item context and scan counters.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      act_r    <= in_act;
      addr_r   <= in_addr;
      bitpos_r <= in_bitpos;
      bit_r    <= 1'b0;
      cx_r     <= '0;
      cy_r     <= '0;
      cz_r     <= '0;
    end
    if (state_r == ST_FETCH) begin
      bit_r <= ram_rdata[bitpos_r];
    end
    if (state_r == ST_SCAN) begin
      pbx_r <= bx;
      pby_r <= by;
      pbz_r <= bz;
      if (z_last) begin
        cz_r <= '0;
        if (y_last) begin
          cy_r <= '0;
          cx_r <= cx_r + XW'(1);
        end else begin
          cy_r <= cy_r + YW'(1);
        end
      end else begin
        cz_r <= cz_r + ZW'(1);
      end
    end
  end

  // Fold one scanned word into the running extent.
  logic [CUBE_EDGE-1:0] col_ok, row_ok, lvl_ok;
  logic [CUBE_EDGE-1:0] col_occ, row_occ, lvl_occ;
  logic [RW-1:0]        col_lo, col_hi, row_lo, row_hi, lvl_lo, lvl_hi;
  logic                 word_hit;
  logic [DIM_W-1:0]     cand_xs, cand_xe, cand_ys, cand_ye, cand_zs, cand_ze;

  always_comb begin
    col_occ = '0;
    row_occ = '0;
    lvl_occ = '0;
    for (int i = 0; i < CUBE_EDGE; i++) begin
      col_ok[i] = (pbx_r + BASE_W'(i)) < BASE_W'(dx);
      row_ok[i] = (pby_r + BASE_W'(i)) < BASE_W'(dy);
      lvl_ok[i] = (pbz_r + BASE_W'(i)) < BASE_W'(dz);
    end
    for (int i = 0; i < CUBE_EDGE; i++) begin
      for (int j = 0; j < CUBE_EDGE; j++) begin
        for (int k = 0; k < CUBE_EDGE; k++) begin
          if (ram_rdata[i * CUBE_EDGE * CUBE_EDGE + j * CUBE_EDGE + k] &&
              col_ok[i] && row_ok[j] && lvl_ok[k]) begin
            col_occ[i] = 1'b1;
            row_occ[j] = 1'b1;
            lvl_occ[k] = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    col_lo = '0;
    col_hi = '0;
    row_lo = '0;
    row_hi = '0;
    lvl_lo = '0;
    lvl_hi = '0;
    for (int i = CUBE_EDGE - 1; i >= 0; i--) begin
      if (col_occ[i]) col_lo = RW'(i);
      if (row_occ[i]) row_lo = RW'(i);
      if (lvl_occ[i]) lvl_lo = RW'(i);
    end
    for (int i = 0; i < CUBE_EDGE; i++) begin
      if (col_occ[i]) col_hi = RW'(i);
      if (row_occ[i]) row_hi = RW'(i);
      if (lvl_occ[i]) lvl_hi = RW'(i);
    end
  end

  assign word_hit = |col_occ;
  assign cand_xs  = DIM_W'(pbx_r + BASE_W'(col_lo));
  assign cand_xe  = DIM_W'(pbx_r + BASE_W'(col_hi));
  assign cand_ys  = DIM_W'(pby_r + BASE_W'(row_lo));
  assign cand_ye  = DIM_W'(pby_r + BASE_W'(row_hi));
  assign cand_zs  = DIM_W'(pbz_r + BASE_W'(lvl_lo));
  assign cand_ze  = DIM_W'(pbz_r + BASE_W'(lvl_hi));

  // Starts begin at the dimension, so any in-volume candidate is smaller.
  logic             found_r;
  logic [DIM_W-1:0] xs_r, xe_r, ys_r, ye_r, zs_r, ze_r;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      found_r <= 1'b0;
      xs_r    <= dx;
      ys_r    <= dy;
      zs_r    <= dz;
      xe_r    <= '0;
      ye_r    <= '0;
      ze_r    <= '0;
    end else if (pend_r && word_hit) begin
      found_r <= 1'b1;
      if (cand_xs < xs_r) xs_r <= cand_xs;
      if (cand_ys < ys_r) ys_r <= cand_ys;
      if (cand_zs < zs_r) zs_r <= cand_zs;
      if (!found_r || cand_xe > xe_r) xe_r <= cand_xe;
      if (!found_r || cand_ye > ye_r) ye_r <= cand_ye;
      if (!found_r || cand_ze > ze_r) ze_r <= cand_ze;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_bus.bit_value  <= (act_r == ACT_GET) ? bit_r : 1'b0;
      out_bus.area_found <= 1'b0;
      out_bus.x_start    <= '0;
      out_bus.x_end      <= '0;
      out_bus.y_start    <= '0;
      out_bus.y_end      <= '0;
      out_bus.z_start    <= '0;
      out_bus.z_end      <= '0;
      if (act_r == ACT_BOX) begin
        out_bus.area_found <= found_r;
        out_bus.x_start    <= xs_r;
        out_bus.y_start    <= ys_r;
        out_bus.z_start    <= zs_r;
        out_bus.x_end      <= found_r ? xe_r : '1;
        out_bus.y_end      <= found_r ? ye_r : '1;
        out_bus.z_end      <= found_r ? ze_r : '1;
      end
    end
  end

  assign out_bus.valid = out_valid_r;

endmodule
